### hdl/iasp_pkg.sv
// shared constants, types and helpers for the imu angle sentence parser
`timescale 1ns / 1ps

package iasp_pkg;

	localparam int FRAC_DIGITS = 2;
	localparam int LINE_MAX    = 64;

	function automatic int unsigned pow10(input int unsigned n);
		int unsigned r;
		r = 1;
		for (int unsigned i = 0; i < n; i++) begin
			r = r * 10;
		end
		return r;
	endfunction

	localparam int SAT_LIMIT = int'(pow10(3 + FRAC_DIGITS)) - 1;
	localparam int MAG_W     = $clog2(SAT_LIMIT + 1);
	localparam int ANG_W     = MAG_W + 1;
	localparam int YAW_W     = 16;
	localparam int SUM_W     = MAG_W + 4;
	localparam int SCALE_W   = $clog2(int'(pow10(FRAC_DIGITS)) + 1);
	localparam int PROD_W    = MAG_W + SCALE_W;
	localparam int FCNT_W    = (FRAC_DIGITS > 0) ? $clog2(FRAC_DIGITS + 1) : 1;
	localparam int LEN_W     = $clog2(LINE_MAX + 1);
	localparam int DIFF_W    = ANG_W + 1;

	localparam int HALF_TURN = 180 * int'(pow10(FRAC_DIGITS));
	localparam int FULL_TURN = 2 * HALF_TURN;
	// largest number of whole turns a reference difference can hold
	localparam int WRAP_N    = (2 * SAT_LIMIT - HALF_TURN + FULL_TURN - 1) / FULL_TURN;
	localparam int WRAP_CW   = $clog2(WRAP_N + 1);

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [1:0] FIELD_NONE = 2'd3;

	typedef enum logic [1:0] {
		PH_LEAD,
		PH_INT,
		PH_FRAC,
		PH_DONE
	} iasp_phase_t;

	// one finished sentence handed from the parser to the angle tracker
	typedef struct packed {
		logic signed [ANG_W-1:0] roll;
		logic signed [ANG_W-1:0] pitch;
		logic signed [ANG_W-1:0] yaw;
		logic [2:0]              present;
		logic                    dropped;
	} iasp_event_t;

	// 10^(FRAC_DIGITS - fcnt): scales a short fraction up to full resolution
	function automatic logic [SCALE_W-1:0] frac_scale(input logic [FCNT_W-1:0] fcnt);
		logic [SCALE_W-1:0] r;
		r = SCALE_W'(1);
		for (int i = 0; i < FRAC_DIGITS; i++) begin
			if (fcnt <= FCNT_W'(i)) begin
				r = SCALE_W'(r * SCALE_W'(10));
			end
		end
		return r;
	endfunction

endpackage

### hdl/iasp_line_parser.sv
// per-byte sentence parser: token state, field values and the sentence register
`timescale 1ns / 1ps

module iasp_line_parser (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  byte_fire,
	input  logic [7:0]            byte_s1,
	input  logic                  ev_take,
	output logic                  ev_valid_s2,
	output iasp_pkg::iasp_event_t ev_s2
);
	import iasp_pkg::*;

	localparam logic [FCNT_W-1:0] FRAC_CNT = FCNT_W'(FRAC_DIGITS);
	localparam logic [MAG_W-1:0]  MAG_CAP  = MAG_W'(SAT_LIMIT);
	localparam logic [LEN_W-1:0]  LEN_CAP  = LEN_W'(LINE_MAX);

	logic                    started_q, started_d;
	logic [1:0]              field_q, field_d;
	logic                    open_q, open_d;
	iasp_phase_t             phase_q, phase_d;
	logic                    neg_q, neg_d;
	logic [MAG_W-1:0]        mag_q, mag_d;
	logic [FCNT_W-1:0]       fcnt_q, fcnt_d;
	logic [LEN_W-1:0]        len_q, len_d;
	logic                    cut_q, cut_d;
	logic signed [ANG_W-1:0] vals_q [3];
	logic signed [ANG_W-1:0] vals_d [3];
	logic [2:0]              present_q, present_d;

	logic signed [ANG_W-1:0] vals_c [3];
	logic [2:0]              present_c;
	logic [1:0]              field_c;
	logic [PROD_W-1:0]       prod;
	logic [MAG_W-1:0]        close_mag;
	logic signed [ANG_W-1:0] close_val;
	logic                    do_close;

	iasp_phase_t             p_eff;
	logic                    n_eff;
	logic [MAG_W-1:0]        m_eff;
	logic [FCNT_W-1:0]       f_eff;
	logic [SUM_W-1:0]        digit_sum;
	logic [MAG_W-1:0]        mag_add;
	logic                    is_space;
	logic                    is_digit;
	logic                    cut_now;
	logic                    ev_load;
	iasp_event_t             ev_d;

	assign ev_load = byte_fire && (byte_s1 == CH_LF);

	// value of the open token if it were closed now
	always_comb begin
		prod      = PROD_W'(mag_q) * PROD_W'(frac_scale(fcnt_q));
		close_mag = (prod > PROD_W'(SAT_LIMIT)) ? MAG_CAP : prod[MAG_W-1:0];
		close_val = neg_q ? -$signed({1'b0, close_mag}) : $signed({1'b0, close_mag});
		do_close  = open_q && (field_q != FIELD_NONE);
		vals_c    = vals_q;
		present_c = present_q;
		field_c   = field_q;
		if (do_close) begin
			vals_c[field_q]    = close_val;
			present_c[field_q] = 1'b1;
			field_c            = field_q + 2'd1;
		end
	end

	always_comb begin
		is_space = (byte_s1 == CH_SPACE) || ((byte_s1 >= CH_TAB) && (byte_s1 <= CH_CR));
		is_digit = (byte_s1 >= CH_ZERO) && (byte_s1 <= CH_NINE);
		// a byte that opens a token starts from a fresh number
		p_eff = open_q ? phase_q : PH_LEAD;
		n_eff = open_q ? neg_q : 1'b0;
		m_eff = open_q ? mag_q : '0;
		f_eff = open_q ? fcnt_q : '0;
		digit_sum = SUM_W'(m_eff) * SUM_W'(10) + SUM_W'(byte_s1 - CH_ZERO);
		mag_add   = (digit_sum > SUM_W'(SAT_LIMIT)) ? MAG_CAP : digit_sum[MAG_W-1:0];
		cut_now   = cut_q || (len_q >= LEN_CAP);

		started_d = started_q;
		field_d   = field_q;
		open_d    = open_q;
		phase_d   = phase_q;
		neg_d     = neg_q;
		mag_d     = mag_q;
		fcnt_d    = fcnt_q;
		len_d     = len_q;
		cut_d     = cut_q;
		vals_d    = vals_q;
		present_d = present_q;

		ev_d.roll    = vals_c[0];
		ev_d.pitch   = vals_c[1];
		ev_d.yaw     = vals_c[2];
		ev_d.present = cut_q ? 3'b000 : present_c;
		ev_d.dropped = cut_q;

		if (ev_load) begin
			if (!cut_q) begin
				vals_d = vals_c;
			end
			started_d = 1'b0;
			field_d   = '0;
			open_d    = 1'b0;
			phase_d   = PH_LEAD;
			neg_d     = 1'b0;
			mag_d     = '0;
			fcnt_d    = '0;
			len_d     = '0;
			cut_d     = 1'b0;
			present_d = '0;
		end else if (byte_fire) begin
			if (len_q < LEN_CAP) begin
				len_d = len_q + LEN_W'(1);
			end
			cut_d = cut_now;
			if (!cut_now) begin
				priority if (byte_s1 == CH_NUL) begin
					// zero byte ends the line text
					vals_d    = vals_c;
					present_d = present_c;
					open_d    = 1'b0;
					started_d = 1'b1;
					field_d   = FIELD_NONE;
				end else if (!started_q) begin
					if (byte_s1 == CH_STAR) begin
						started_d = 1'b1;
					end
				end else if (field_q == FIELD_NONE) begin
					// past the third token
				end else if (byte_s1 == CH_COMMA) begin
					vals_d    = vals_c;
					present_d = present_c;
					field_d   = field_c;
					open_d    = 1'b0;
				end else begin
					open_d  = 1'b1;
					phase_d = p_eff;
					neg_d   = n_eff;
					mag_d   = m_eff;
					fcnt_d  = f_eff;
					unique case (p_eff)
						PH_LEAD, PH_INT: begin
							priority if (is_space && (p_eff == PH_LEAD)) begin
								// leading whitespace
							end else if ((p_eff == PH_LEAD) &&
									((byte_s1 == CH_PLUS) || (byte_s1 == CH_MINUS))) begin
								neg_d   = (byte_s1 == CH_MINUS);
								phase_d = PH_INT;
							end else if (is_digit) begin
								mag_d   = mag_add;
								phase_d = PH_INT;
							end else if (byte_s1 == CH_DOT) begin
								phase_d = PH_FRAC;
							end else begin
								phase_d = PH_DONE;
							end
						end
						PH_FRAC: begin
							if (is_digit) begin
								if (f_eff < FRAC_CNT) begin
									mag_d  = mag_add;
									fcnt_d = f_eff + FCNT_W'(1);
								end
							end else begin
								phase_d = PH_DONE;
							end
						end
						PH_DONE: begin
						end
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			field_q   <= '0;
			open_q    <= 1'b0;
			phase_q   <= PH_LEAD;
			neg_q     <= 1'b0;
			mag_q     <= '0;
			fcnt_q    <= '0;
			len_q     <= '0;
			cut_q     <= 1'b0;
			present_q <= '0;
			for (int i = 0; i < 3; i++) begin
				vals_q[i] <= '0;
			end
		end else begin
			started_q <= started_d;
			field_q   <= field_d;
			open_q    <= open_d;
			phase_q   <= phase_d;
			neg_q     <= neg_d;
			mag_q     <= mag_d;
			fcnt_q    <= fcnt_d;
			len_q     <= len_d;
			cut_q     <= cut_d;
			present_q <= present_d;
			vals_q    <= vals_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_valid_s2 <= 1'b0;
		end else if (ev_load) begin
			ev_valid_s2 <= 1'b1;
		end else if (ev_take) begin
			ev_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ev_load) begin
			ev_s2 <= ev_d;
		end
	end

	a_mag_cap: assert property (@(posedge clk) disable iff (!arst_n)
		mag_q <= MAG_CAP)
		else $error("token magnitude above saturation limit");

	a_fcnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		fcnt_q <= FRAC_CNT)
		else $error("fraction digit count above limit");

	a_line_clear: assert property (@(posedge clk) disable iff (!arst_n)
		ev_load |=> (len_q == '0) && !cut_q && (present_q == '0))
		else $error("line state not cleared after line feed");

endmodule

### hdl/iasp_angle_track.sv
// angle registers, yaw reference and wrap, and the result register
`timescale 1ns / 1ps

module iasp_angle_track (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               ev_valid_s2,
	input  iasp_pkg::iasp_event_t              ev_s2,
	output logic                               ev_take,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [iasp_pkg::ANG_W-1:0]  roll_value,
	output logic signed [iasp_pkg::ANG_W-1:0]  pitch_value,
	output logic signed [iasp_pkg::YAW_W-1:0]  yaw_value,
	output logic                               roll_fresh,
	output logic                               pitch_fresh,
	output logic                               yaw_fresh,
	output logic                               line_dropped
);
	import iasp_pkg::*;

	localparam logic signed [DIFF_W-1:0] FULL_S   = DIFF_W'(FULL_TURN);
	localparam logic signed [YAW_W-1:0]  YAW_HALF = YAW_W'(HALF_TURN);

	logic                    out_valid_q;
	logic signed [ANG_W-1:0] roll_q;
	logic signed [ANG_W-1:0] pitch_q;
	logic signed [YAW_W-1:0] yaw_q;
	logic [2:0]              fresh_q;
	logic                    dropped_q;
	logic signed [ANG_W-1:0] ref_q;
	logic                    ref_taken_q;

	logic signed [ANG_W-1:0]  ref_use;
	logic signed [DIFF_W-1:0] diff;
	logic signed [DIFF_W-1:0] wrapped;
	logic [WRAP_CW-1:0]       k_pos;
	logic [WRAP_CW-1:0]       k_neg;

	assign ev_take = ev_valid_s2 && (!out_valid_q || out_ready);

	// count whole turns past each half turn, then take them off in one add
	always_comb begin
		ref_use = ref_taken_q ? ref_q : ev_s2.yaw;
		diff    = DIFF_W'(ev_s2.yaw) - DIFF_W'(ref_use);
		k_pos   = '0;
		k_neg   = '0;
		for (int i = 0; i < WRAP_N; i++) begin
			if (diff > DIFF_W'(HALF_TURN + i * FULL_TURN)) begin
				k_pos = k_pos + WRAP_CW'(1);
			end
			if (diff < -DIFF_W'(HALF_TURN + i * FULL_TURN)) begin
				k_neg = k_neg + WRAP_CW'(1);
			end
		end
		wrapped = diff - $signed(DIFF_W'(k_pos)) * FULL_S + $signed(DIFF_W'(k_neg)) * FULL_S;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			roll_q      <= '0;
			pitch_q     <= '0;
			yaw_q       <= '0;
			fresh_q     <= '0;
			dropped_q   <= 1'b0;
			ref_q       <= '0;
			ref_taken_q <= 1'b0;
		end else begin
			if (ev_take) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (ev_take) begin
				fresh_q   <= ev_s2.present;
				dropped_q <= ev_s2.dropped;
				if (ev_s2.present[0]) begin
					roll_q <= ev_s2.roll;
				end
				if (ev_s2.present[1]) begin
					pitch_q <= ev_s2.pitch;
				end
				if (ev_s2.present[2]) begin
					yaw_q       <= wrapped[YAW_W-1:0];
					ref_q       <= ref_use;
					ref_taken_q <= 1'b1;
				end
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign roll_value   = roll_q;
	assign pitch_value  = pitch_q;
	assign yaw_value    = yaw_q;
	assign roll_fresh   = fresh_q[0];
	assign pitch_fresh  = fresh_q[1];
	assign yaw_fresh    = fresh_q[2];
	assign line_dropped = dropped_q;

	a_yaw_range: assert property (@(posedge clk) disable iff (!arst_n)
		(yaw_q <= YAW_HALF) && (yaw_q >= -YAW_HALF))
		else $error("relative yaw outside half turn");

	a_ref_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		ref_taken_q |=> ref_taken_q && $stable(ref_q))
		else $error("yaw reference changed after first reading");

	a_drop_no_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		dropped_q |-> (fresh_q == 3'b000))
		else $error("dropped line reported fresh angles");

endmodule

### hdl/imu_angle_sentence_parser.sv
// top level: input register and handshake around the parser and angle tracker
//
// Byte stream in, one result word per line feed out. Both channels use
// valid/ready; a word moves on an edge where both are high.
// Input word: line_byte, one received character. Output word: the current
// roll, pitch and relative yaw in hundredths of a degree, the three fresh
// flags and line_dropped.
// Throughput: one byte per cycle while no line feed waits on a stalled
// receiver. Every stage (input register, parser register, result register)
// is a single registered step, so a byte can follow in the very next cycle,
// including back to back line feeds. A line feed's result word passes the
// parser register and then the result register.
// Bytes other than line feed never wait on the output side. A line feed
// waits in the input register only while a finished sentence is parked in
// the parser register and the result register is held by a stalled
// receiver; in_ready drops then and picks up the cycle the receiver takes.
// Reset clears the line state, the angles and the yaw reference; the first
// yaw read after reset becomes the new reference.
`timescale 1ns / 1ps

module imu_angle_sentence_parser (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [7:0]                         line_byte,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [iasp_pkg::ANG_W-1:0]  roll_value,
	output logic signed [iasp_pkg::ANG_W-1:0]  pitch_value,
	output logic signed [iasp_pkg::YAW_W-1:0]  yaw_value,
	output logic                               roll_fresh,
	output logic                               pitch_fresh,
	output logic                               yaw_fresh,
	output logic                               line_dropped
);
	import iasp_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        fire_s1;
	logic        ev_valid_s2;
	logic        ev_take;
	iasp_event_t ev_s2;

	// a line feed needs the sentence register free or draining this cycle
	assign fire_s1  = valid_s1 && ((byte_s1 != CH_LF) || !ev_valid_s2 || ev_take);
	assign in_ready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= line_byte;
		end
	end

	iasp_line_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_fire   (fire_s1),
		.byte_s1     (byte_s1),
		.ev_take     (ev_take),
		.ev_valid_s2 (ev_valid_s2),
		.ev_s2       (ev_s2)
	);

	iasp_angle_track u_track (
		.clk          (clk),
		.arst_n       (arst_n),
		.ev_valid_s2  (ev_valid_s2),
		.ev_s2        (ev_s2),
		.ev_take      (ev_take),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.roll_value   (roll_value),
		.pitch_value  (pitch_value),
		.yaw_value    (yaw_value),
		.roll_fresh   (roll_fresh),
		.pitch_fresh  (pitch_fresh),
		.yaw_fresh    (yaw_fresh),
		.line_dropped (line_dropped)
	);

	a_lf_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && (byte_s1 == CH_LF) && ev_valid_s2 && !ev_take) |-> !fire_s1)
		else $error("line feed passed a full sentence register");

	a_s2_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(ev_valid_s2 && !ev_take) |=> ev_valid_s2 && $stable(ev_s2))
		else $error("parked sentence lost or changed");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !fire_s1) |-> !in_ready)
		else $error("input register overwritten while held");

endmodule

### tb/sv/tb_imu_angle_sentence_parser.sv
// self-checking testbench for the imu angle sentence parser
`timescale 1ns / 1ps

module tb_imu_angle_sentence_parser;
	import iasp_pkg::*;

	localparam int FIELD_COUNT  = 3;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int PHASE_BYTES  = 435;
	localparam int DRAIN_CYCLES = 8;

	typedef struct {
		int roll;
		int pitch;
		int yaw;
		bit roll_f;
		bit pitch_f;
		bit yaw_f;
		bit dropped;
	} angle_report_t;

	// mirrors the parser: line state, angles and yaw reference, one report per line feed
	class angle_tracker;
		int errors;
		angle_report_t pending_reports[$];
		bit started, tok_open, neg, cut, have_ref;
		int fld, mag, fcnt, len;
		int roll, pitch, yaw, yaw_ref;
		int vals[FIELD_COUNT];
		bit [2:0] present;
		iasp_phase_t phase;
		longint sat_cap;

		function new();
			errors = 0;
			roll = 0;
			pitch = 0;
			yaw = 0;
			yaw_ref = 0;
			have_ref = 0;
			foreach (vals[i]) vals[i] = 0;
			sat_cap = ten_to(3 + FRAC_DIGITS) - 1;
			clear_line();
		endfunction

		function longint ten_to(int n);
			longint r;
			r = 1;
			for (int i = 0; i < n; i++) r = r * 10;
			return r;
		endfunction

		function void clear_line();
			started = 0;
			fld = 0;
			tok_open = 0;
			phase = PH_LEAD;
			neg = 0;
			mag = 0;
			fcnt = 0;
			len = 0;
			cut = 0;
			present = '0;
		endfunction

		function void close_token();
			longint v;
			int shift;
			if (tok_open && fld < FIELD_COUNT) begin
				shift = (fcnt < FRAC_DIGITS) ? FRAC_DIGITS - fcnt : 0;
				v = longint'(mag) * ten_to(shift);
				if (v > sat_cap) v = sat_cap;
				vals[fld] = neg ? -int'(v) : int'(v);
				present[fld] = 1'b1;
				fld++;
			end
			tok_open = 0;
		endfunction

		function void add_digit(int d);
			longint v;
			v = longint'(mag) * 10 + d;
			mag = (v > sat_cap) ? int'(sat_cap) : int'(v);
		endfunction

		function void feed_char(logic [7:0] b);
			bit space, digit;
			space = (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
			digit = (b >= CH_ZERO && b <= CH_NINE);
			if (phase == PH_LEAD) begin
				if (space) return;
				if (b == CH_PLUS || b == CH_MINUS) begin
					neg = (b == CH_MINUS);
					phase = PH_INT;
					return;
				end
			end
			case (phase)
				PH_LEAD, PH_INT: begin
					if (digit) begin
						add_digit(int'(b - CH_ZERO));
						phase = PH_INT;
					end else if (b == CH_DOT) begin
						phase = PH_FRAC;
					end else begin
						phase = PH_DONE;
					end
				end
				PH_FRAC: begin
					if (digit) begin
						if (fcnt < FRAC_DIGITS) begin
							add_digit(int'(b - CH_ZERO));
							fcnt++;
						end
					end else begin
						phase = PH_DONE;
					end
				end
				default: ;
			endcase
		endfunction

		function void take_byte(logic [7:0] b);
			angle_report_t r;
			int diff, half;
			if (b == CH_LF) begin
				r.dropped = cut;
				if (!cut) begin
					close_token();
					if (present[0]) roll = vals[0];
					if (present[1]) pitch = vals[1];
					if (present[2]) begin
						half = 180 * int'(ten_to(FRAC_DIGITS));
						if (!have_ref) begin
							yaw_ref = vals[2];
							have_ref = 1;
						end
						diff = vals[2] - yaw_ref;
						while (diff > half) diff -= 2 * half;
						while (diff < -half) diff += 2 * half;
						yaw = diff;
					end
				end
				r.roll = roll;
				r.pitch = pitch;
				r.yaw = yaw;
				r.roll_f = !cut && present[0];
				r.pitch_f = !cut && present[1];
				r.yaw_f = !cut && present[2];
				pending_reports.push_back(r);
				clear_line();
				return;
			end
			if (len >= LINE_MAX) cut = 1;
			else len++;
			if (cut) return;
			// zero byte ends the parsed text, rest of the line is only counted
			if (b == CH_NUL) begin
				close_token();
				started = 1;
				fld = FIELD_COUNT;
				return;
			end
			if (!started) begin
				if (b == CH_STAR) started = 1;
				return;
			end
			if (fld >= FIELD_COUNT) return;
			if (b == CH_COMMA) begin
				close_token();
				return;
			end
			if (!tok_open) begin
				tok_open = 1;
				phase = PH_LEAD;
				neg = 0;
				mag = 0;
				fcnt = 0;
			end
			feed_char(b);
		endfunction

		function void compare_field(string name, int want, logic signed [31:0] got);
			if (got !== want) begin
				$display("%0t %s expected %0d got %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_report(logic signed [31:0] roll_a, logic signed [31:0] pitch_a,
				logic signed [31:0] yaw_a, logic signed [31:0] roll_fa,
				logic signed [31:0] pitch_fa, logic signed [31:0] yaw_fa,
				logic signed [31:0] dropped_a);
			angle_report_t want;
			if (pending_reports.size() == 0) begin
				$display("%0t unexpected word: expected none got roll %0d pitch %0d yaw %0d",
					$time, roll_a, pitch_a, yaw_a);
				errors++;
				return;
			end
			want = pending_reports.pop_front();
			compare_field("roll_value", want.roll, roll_a);
			compare_field("pitch_value", want.pitch, pitch_a);
			compare_field("yaw_value", want.yaw, yaw_a);
			compare_field("roll_fresh", int'(want.roll_f), roll_fa);
			compare_field("pitch_fresh", int'(want.pitch_f), pitch_fa);
			compare_field("yaw_fresh", int'(want.yaw_f), yaw_fa);
			compare_field("line_dropped", int'(want.dropped), dropped_a);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] line_byte = 8'h00;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [ANG_W-1:0] roll_value;
	logic signed [ANG_W-1:0] pitch_value;
	logic signed [YAW_W-1:0] yaw_value;
	logic roll_fresh, pitch_fresh, yaw_fresh, line_dropped;

	angle_tracker tracker;
	logic [7:0] line_buf[$];
	int send_gap = 8;
	int recv_gap = 73;
	int bytes_sent = 0;
	int cycles = 0;

	imu_angle_sentence_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.line_byte(line_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.roll_value(roll_value),
		.pitch_value(pitch_value),
		.yaw_value(yaw_value),
		.roll_fresh(roll_fresh),
		.pitch_fresh(pitch_fresh),
		.yaw_fresh(yaw_fresh),
		.line_dropped(line_dropped)
	);

	always #2 clk = ~clk;

	// result side: check every word taken, then pick ready for the next edge
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end else begin
			if (arst_n && out_valid && out_ready)
				tracker.check_report(32'(roll_value), 32'(pitch_value), 32'(yaw_value),
					32'(roll_fresh), 32'(pitch_fresh), 32'(yaw_fresh),
					32'(line_dropped));
			out_ready <= ($urandom_range(99) >= recv_gap);
		end
	end

	function automatic void put(logic [7:0] c);
		line_buf.push_back(c);
	endfunction

	function automatic void put_text(string s);
		for (int i = 0; i < s.len(); i++) put(s[i]);
	endfunction

	// value in hundredths of a degree written as decimal text
	function automatic void put_value(int v);
		int a;
		a = (v < 0) ? -v : v;
		if (v < 0) put(CH_MINUS);
		put_text($sformatf("%0d.%02d", a / 100, a % 100));
	endfunction

	function automatic void put_number();
		int n_int;
		string junk;
		junk = "a*x+.-";
		if ($urandom_range(3) == 0) put($urandom_range(1) ? CH_SPACE : CH_TAB);
		case ($urandom_range(2))
			1: put(CH_PLUS);
			2: put(CH_MINUS);
			default: ;
		endcase
		// some long digit runs to drive saturation
		n_int = ($urandom_range(7) == 0) ? $urandom_range(4, 6) : $urandom_range(0, 3);
		repeat (n_int) put(8'(CH_ZERO + $urandom_range(9)));
		if ($urandom_range(2) != 0) begin
			put(CH_DOT);
			repeat ($urandom_range(4)) put(8'(CH_ZERO + $urandom_range(9)));
		end
		if ($urandom_range(5) == 0) put(junk[$urandom_range(junk.len() - 1)]);
	endfunction

	function automatic void build_line();
		int pick, n_tok, v;
		string pool;
		pool = "0123456789.,+- *\tabc\r";
		pick = $urandom_range(99);
		if (pick < 62) begin
			if ($urandom_range(3) == 0)
				repeat ($urandom_range(1, 3)) put(8'(8'h41 + $urandom_range(25)));
			put(CH_STAR);
			if ($urandom_range(4) == 0) put(CH_COMMA);
			n_tok = $urandom_range(1, 4);
			for (int i = 0; i < n_tok; i++) begin
				if (i > 0) begin
					put(CH_COMMA);
					if ($urandom_range(5) == 0) put(CH_COMMA);
				end
				// yaw at the wrap point or one hundredth either side of it
				v = tracker.yaw_ref + ($urandom_range(1) ? 18000 : -18000)
					+ $urandom_range(2) - 1;
				if (i == 2 && tracker.have_ref && $urandom_range(3) == 0
						&& v <= 99999 && v >= -99999)
					put_value(v);
				else
					put_number();
			end
			if ($urandom_range(7) == 0) begin
				put(CH_NUL);
				put_text("9,9");
			end
			if ($urandom_range(4) == 0) put(CH_CR);
		end else if (pick < 70) begin
			// around the line length limit
			put(CH_STAR);
			repeat ($urandom_range(LINE_MAX - 3, LINE_MAX + 5))
				put(pool[$urandom_range(13)]);
		end else if (pick < 85) begin
			repeat ($urandom_range(1, 12)) put(8'($urandom_range(255)));
		end else begin
			put(CH_STAR);
			repeat ($urandom_range(1, 20)) begin
				if ($urandom_range(15) == 0) put(CH_NUL);
				else put(pool[$urandom_range(pool.len() - 1)]);
			end
		end
		put(CH_LF);
	endfunction

	task automatic send_byte(logic [7:0] b);
		while ($urandom_range(99) < send_gap) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		line_byte <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		tracker.take_byte(b);
		bytes_sent++;
	endtask

	task automatic send_buf();
		foreach (line_buf[i]) send_byte(line_buf[i]);
		line_buf.delete();
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (tracker.pending_reports.size() != 0);
	endtask

	initial begin
		tracker = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// saturation, negative zero, first yaw as reference
		put_text("*1000.5,-0,7");
		put(CH_LF);
		// skipped empty tokens, blank token, yaw wrapping past -180
		put_text("*,,3.1, ,-190");
		put(CH_CR);
		put(CH_LF);
		// fraction truncation, bare dot, zero byte ending the text
		put_text("*-2.345,+7.,.5");
		put(CH_NUL);
		put_text("1,2");
		put(CH_LF);
		send_buf();

		for (int p = 0; p < 3; p++) begin
			case (p)
				0: begin send_gap = 8; recv_gap = 73; end
				1: begin send_gap = 73; recv_gap = 8; end
				default: begin send_gap = 0; recv_gap = 0; end
			endcase
			bytes_sent = 0;
			while (bytes_sent < PHASE_BYTES) begin
				build_line();
				send_buf();
			end
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending_reports.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

### files.f
hdl/iasp_pkg.sv
hdl/iasp_line_parser.sv
hdl/iasp_angle_track.sv
hdl/imu_angle_sentence_parser.sv
tb/sv/tb_imu_angle_sentence_parser.sv
